[hw/rtl/mfs_pkg.sv]
// ============================================================================
// mfs_pkg
// Shared types, opcodes, status codes and constants for the MIDI file
// serializer.
// ============================================================================
package mfs_pkg;

    // Address width default and fixed field widths
    localparam int ADDRESS_BITS_DEFAULT = 24;
    localparam int OUT_ADDR_W           = 24;
    localparam int WORD_W               = 32;
    localparam int CNT_W                = 24;
    localparam int MAX_BYTES            = 14;
    localparam int BCOUNT_W             = $clog2(MAX_BYTES + 1);
    localparam int IDX_W                = $clog2(MAX_BYTES);
    localparam int TRACK_HDR_LEN        = 8;
    localparam int LEN_FIELD_OFS        = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Input opcodes
    localparam logic [2:0] OP_BEGIN_FILE  = 3'd0;
    localparam logic [2:0] OP_BEGIN_TRACK = 3'd1;
    localparam logic [2:0] OP_DELTA       = 3'd2;
    localparam logic [2:0] OP_EVENT       = 3'd3;
    localparam logic [2:0] OP_END_TRACK   = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_FORMAT  = 3'd1;
    localparam logic [2:0] ST_NO_TRACKS   = 3'd2;
    localparam logic [2:0] ST_F0_MULTI    = 3'd3;
    localparam logic [2:0] ST_BAD_DIV     = 3'd4;
    localparam logic [2:0] ST_EMPTY_TRACK = 3'd5;
    localparam logic [2:0] ST_NO_EOT      = 3'd6;
    localparam logic [2:0] ST_DELTA_RANGE = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_FILE_FORMAT = 2'd0;
    localparam logic [1:0] CFG_TRACK_COUNT = 2'd1;
    localparam logic [1:0] CFG_DIVISION    = 2'd2;

    // Configuration reset values and limits
    localparam logic [1:0]  FORMAT_RESET = 2'd1;
    localparam logic [15:0] TRACKS_RESET = 16'd1;
    localparam logic [15:0] DIV_RESET    = 16'd96;
    localparam logic [1:0]  FORMAT_MAX   = 2'd2;
    localparam logic [1:0]  FORMAT_SINGLE = 2'd0;

    // Chunk tags and fixed bytes
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_H = 8'h68;
    localparam logic [7:0] CH_D = 8'h64;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_K = 8'h6B;
    localparam logic [7:0] HDR_DATA_LEN = 8'd6;
    localparam logic [7:0] VLQ_MORE     = 8'h80;
    localparam logic [23:0] END_OF_TRACK = 24'hFF2F00;

    typedef logic [7:0] octet_t;

    typedef struct packed {
        logic [1:0]  file_format;
        logic [15:0] track_count;
        logic [15:0] division;
    } cfg_t;

    // One item's worth of results, emitted at consecutive addresses
    typedef struct packed {
        octet_t [MAX_BYTES-1:0] bytes;
        logic [BCOUNT_W-1:0]    count;
        logic                   write_valid;
        logic [2:0]             status;
    } burst_t;

endpackage

[hw/rtl/midi_file_serializer_unit.sv]
// ============================================================================
// midi_file_serializer_unit
// Standard MIDI file writer producing addressed byte writes.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) takes one opcode transaction: begin
//   file, begin track, delta time, event byte or end track. Output channel
//   (out_valid/out_ready) returns byte writes; last marks the final result
//   of each input transaction. Failed checks give one status-only result.
//   Configuration (cfg_valid/cfg_ready, always ready) sets file format,
//   track count and division; write it only while the block is idle.
// Pipeline and throughput:
//   An accepted item passes the input, burst and output registers.
//   Results leave at one per cycle while out_ready does not stall them,
//   a rate set by the burst register feeding the output register. An item
//   holds the burst register until all its results have left: 1 for an
//   event byte or a failed check, 1 to 4 for a delta, 4 for end track, 8
//   for begin track, 14 for begin file. Unused opcodes are dropped unanswered.
// Reset and stall:
//   Reset empties the pipeline, zeroes the write pointer and track state
//   and loads format 1, one track, division 96. A stalled receiver holds
//   the output register; the burst and input registers then fill and
//   in_ready drops.
// ============================================================================
module midi_file_serializer_unit
    import mfs_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            opcode,
    input  logic [WORD_W-1:0]     delta_value,
    input  logic [7:0]            data_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_ADDR_W-1:0] byte_address,
    output logic [7:0]            byte_value,
    output logic                  write_valid,
    output logic [2:0]            status,
    output logic                  last
);

    cfg_t                    cfg_reg;
    logic                    in_valid_reg;
    logic [2:0]              opcode_reg;
    logic [WORD_W-1:0]       delta_reg;
    logic [7:0]              data_reg;

    logic                    slot_free;
    logic                    take;
    logic                    load;
    logic                    has_result;
    burst_t                  burst;
    logic [ADDRESS_BITS-1:0] burst_base;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.file_format <= FORMAT_RESET;
            cfg_reg.track_count <= TRACKS_RESET;
            cfg_reg.division    <= DIV_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FILE_FORMAT: cfg_reg.file_format <= cfg_data[1:0];
                CFG_TRACK_COUNT: cfg_reg.track_count <= cfg_data;
                CFG_DIVISION:    cfg_reg.division    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Input register: refill as soon as its item moves on
    assign take     = in_valid_reg && slot_free;
    assign load     = take && has_result;
    assign in_ready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            opcode_reg <= opcode;
            delta_reg  <= delta_value;
            data_reg   <= data_byte;
        end
    end

    mfs_track_state #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .opcode      (opcode_reg),
        .delta_value (delta_reg),
        .data_byte   (data_reg),
        .load        (load),
        .has_result  (has_result),
        .burst       (burst),
        .burst_base  (burst_base)
    );

    mfs_byte_emitter #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .burst        (burst),
        .burst_base   (burst_base),
        .slot_free    (slot_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .byte_address (byte_address),
        .byte_value   (byte_value),
        .write_valid  (write_valid),
        .status       (status),
        .last         (last)
    );

`ifndef SYNTHESIS
    // A failed check is a single status-only transaction
    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> !write_valid && last)
        else $error("error status on a byte write or a non-final result");

    // Status-only results carry zero address and value
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_valid |-> status != ST_OK && byte_address == '0
        && byte_value == 8'd0)
        else $error("status-only result with bad fields");

    // The input register never drops an item while the emitter is busy
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !slot_free |=> in_valid_reg && $stable(opcode_reg))
        else $error("pending item lost while emitter busy");
`endif

endmodule

[hw/rtl/mfs_track_state.sv]
// ============================================================================
// mfs_track_state
// File and track state, plus the decode of one item into its byte burst.
// ============================================================================
module mfs_track_state
    import mfs_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic [2:0]              opcode,
    input  logic [WORD_W-1:0]       delta_value,
    input  logic [7:0]              data_byte,
    input  logic                    load,
    output logic                    has_result,
    output burst_t                  burst,
    output logic [ADDRESS_BITS-1:0] burst_base
);

    logic [ADDRESS_BITS-1:0] wp_reg, wp_next;
    logic [ADDRESS_BITS-1:0] tho_reg, tho_next;
    logic [CNT_W-1:0]        events_reg, events_next;
    logic [CNT_W-1:0]        since_reg, since_next;
    logic [23:0]             recent_reg, recent_next;

    logic [6:0]              grp3, grp2, grp1, grp0;
    logic [2:0]              vlq_cnt;
    logic [ADDRESS_BITS-1:0] len_a;
    logic [WORD_W-1:0]       len_w;

    // Split the delta into 7-bit groups and size the quantity
    assign grp3 = delta_value[27:21];
    assign grp2 = delta_value[20:14];
    assign grp1 = delta_value[13:7];
    assign grp0 = delta_value[6:0];

    always_comb
    begin
        if (grp3 != 7'd0)
            vlq_cnt = 3'd4;
        else if (grp2 != 7'd0)
            vlq_cnt = 3'd3;
        else if (grp1 != 7'd0)
            vlq_cnt = 3'd2;
        else
            vlq_cnt = 3'd1;
    end

    // Chunk length for the open track
    assign len_a = wp_reg - tho_reg - ADDRESS_BITS'(TRACK_HDR_LEN);
    assign len_w = WORD_W'(len_a);

    // Decode the item into a burst and the next state
    always_comb
    begin
        wp_next     = wp_reg;
        tho_next    = tho_reg;
        events_next = events_reg;
        since_next  = since_reg;
        recent_next = recent_reg;
        burst       = '0;
        burst.count = BCOUNT_W'(1);
        burst_base  = '0;
        has_result  = 1'b1;
        case (opcode)
            OP_BEGIN_FILE:
            begin
                if (cfg.file_format > FORMAT_MAX)
                    burst.status = ST_BAD_FORMAT;
                else if (cfg.track_count == 16'd0)
                    burst.status = ST_NO_TRACKS;
                else if (cfg.file_format == FORMAT_SINGLE && cfg.track_count > 16'd1)
                    burst.status = ST_F0_MULTI;
                else if (cfg.division == 16'd0 || cfg.division[15])
                    burst.status = ST_BAD_DIV;
                else
                begin
                    burst.bytes[0]     = CH_M;
                    burst.bytes[1]     = CH_T;
                    burst.bytes[2]     = CH_H;
                    burst.bytes[3]     = CH_D;
                    burst.bytes[7]     = HDR_DATA_LEN;
                    burst.bytes[9]     = {6'd0, cfg.file_format};
                    burst.bytes[10]    = cfg.track_count[15:8];
                    burst.bytes[11]    = cfg.track_count[7:0];
                    burst.bytes[12]    = cfg.division[15:8];
                    burst.bytes[13]    = cfg.division[7:0];
                    burst.count        = BCOUNT_W'(MAX_BYTES);
                    burst.write_valid  = 1'b1;
                    wp_next            = ADDRESS_BITS'(MAX_BYTES);
                    tho_next           = '0;
                    events_next        = '0;
                    since_next         = '0;
                    recent_next        = '0;
                end
            end
            OP_BEGIN_TRACK:
            begin
                burst.bytes[0]    = CH_M;
                burst.bytes[1]    = CH_T;
                burst.bytes[2]    = CH_R;
                burst.bytes[3]    = CH_K;
                burst.count       = BCOUNT_W'(TRACK_HDR_LEN);
                burst.write_valid = 1'b1;
                burst_base        = wp_reg;
                tho_next          = wp_reg;
                wp_next           = wp_reg + ADDRESS_BITS'(TRACK_HDR_LEN);
                events_next       = '0;
                since_next        = '0;
                recent_next       = '0;
            end
            OP_DELTA:
            begin
                if (delta_value[31:28] != 4'd0)
                    burst.status = ST_DELTA_RANGE;
                else
                begin
                    case (vlq_cnt)
                        3'd4:
                        begin
                            burst.bytes[0] = VLQ_MORE | {1'b0, grp3};
                            burst.bytes[1] = VLQ_MORE | {1'b0, grp2};
                            burst.bytes[2] = VLQ_MORE | {1'b0, grp1};
                            burst.bytes[3] = {1'b0, grp0};
                        end
                        3'd3:
                        begin
                            burst.bytes[0] = VLQ_MORE | {1'b0, grp2};
                            burst.bytes[1] = VLQ_MORE | {1'b0, grp1};
                            burst.bytes[2] = {1'b0, grp0};
                        end
                        3'd2:
                        begin
                            burst.bytes[0] = VLQ_MORE | {1'b0, grp1};
                            burst.bytes[1] = {1'b0, grp0};
                        end
                        default:
                        begin
                            burst.bytes[0] = {1'b0, grp0};
                        end
                    endcase
                    burst.count       = BCOUNT_W'(vlq_cnt);
                    burst.write_valid = 1'b1;
                    burst_base        = wp_reg;
                    wp_next           = wp_reg + ADDRESS_BITS'(vlq_cnt);
                    if (events_reg != CNT_MAX)
                        events_next = events_reg + CNT_W'(1);
                    since_next  = '0;
                    recent_next = '0;
                end
            end
            OP_EVENT:
            begin
                burst.bytes[0]    = data_byte;
                burst.write_valid = 1'b1;
                burst_base        = wp_reg;
                wp_next           = wp_reg + ADDRESS_BITS'(1);
                if (since_reg != CNT_MAX)
                    since_next = since_reg + CNT_W'(1);
                recent_next = {recent_reg[15:0], data_byte};
            end
            OP_END_TRACK:
            begin
                if (events_reg == '0)
                    burst.status = ST_EMPTY_TRACK;
                else if (since_reg != CNT_W'(3) || recent_reg != END_OF_TRACK)
                    burst.status = ST_NO_EOT;
                else
                begin
                    burst.bytes[0]    = len_w[31:24];
                    burst.bytes[1]    = len_w[23:16];
                    burst.bytes[2]    = len_w[15:8];
                    burst.bytes[3]    = len_w[7:0];
                    burst.count       = BCOUNT_W'(LEN_FIELD_OFS);
                    burst.write_valid = 1'b1;
                    burst_base        = tho_reg + ADDRESS_BITS'(LEN_FIELD_OFS);
                    events_next       = '0;
                    since_next        = '0;
                    recent_next       = '0;
                end
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    // Commit the state of the item that moves into the emitter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            tho_reg    <= '0;
            events_reg <= '0;
            since_reg  <= '0;
            recent_reg <= '0;
        end
        else if (load)
        begin
            wp_reg     <= wp_next;
            tho_reg    <= tho_next;
            events_reg <= events_next;
            since_reg  <= since_next;
            recent_reg <= recent_next;
        end
    end

endmodule

[hw/rtl/mfs_byte_emitter.sv]
// ============================================================================
// mfs_byte_emitter
// Holds one item's burst and plays it out one transaction per cycle
// through the output register while out_ready does not stall it.
// ============================================================================
module mfs_byte_emitter
    import mfs_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  burst_t                  burst,
    input  logic [ADDRESS_BITS-1:0] burst_base,
    output logic                    slot_free,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [OUT_ADDR_W-1:0]   byte_address,
    output logic [7:0]              byte_value,
    output logic                    write_valid,
    output logic [2:0]              status,
    output logic                    last
);

    logic                    busy_reg;
    burst_t                  burst_reg;
    logic [ADDRESS_BITS-1:0] base_reg;
    logic [IDX_W-1:0]        idx_reg;

    logic                    out_valid_reg;
    logic [OUT_ADDR_W-1:0]   addr_reg;
    logic [7:0]              value_reg;
    logic                    wv_reg;
    logic [2:0]              status_reg;
    logic                    last_reg;

    logic                    advance;
    logic                    final_byte;
    logic [ADDRESS_BITS-1:0] addr_sum;
    logic [WORD_W-1:0]       addr_wide;

    // Step when the output register is free or being drained
    assign advance    = busy_reg && (!out_valid_reg || out_ready);
    assign final_byte = (BCOUNT_W'(idx_reg) + BCOUNT_W'(1)) == burst_reg.count;
    assign slot_free  = !busy_reg || (advance && final_byte);

    assign addr_sum  = base_reg + ADDRESS_BITS'(idx_reg);
    assign addr_wide = WORD_W'(addr_sum);

    // Hold the burst and walk its index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (advance)
        begin
            if (final_byte)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= burst;
            base_reg  <= burst_base;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            addr_reg   <= addr_wide[OUT_ADDR_W-1:0];
            value_reg  <= burst_reg.bytes[idx_reg];
            wv_reg     <= burst_reg.write_valid;
            status_reg <= burst_reg.status;
            last_reg   <= final_byte;
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_address = addr_reg;
    assign byte_value   = value_reg;
    assign write_valid  = wv_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule
